>>> hdl/gbs_pkg.sv
// Shared types, constants and the kernel sum function of the 3x3 Gaussian blur stream.
// Used by every module of the block but the line store; depends on nothing else.
`timescale 1ns / 1ps

package gbs_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 4096;
	localparam int unsigned IMG_W_W       = 13;
	localparam int unsigned ROW_W         = 16;
	localparam int unsigned COL_W         = 12;
	localparam int unsigned PIX_W         = 8;
	localparam int unsigned OUT_TDATA_W   = 40;

	localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 13'd4096;
	localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd4096;

	// Register select, taken from paddr bit 2.
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// ceil(2^16 / 9); exact truncated quotient for every sum below 32768.
	localparam logic [12:0] RECIP9 = 13'd7282;

	// Window element (row * 3 + column); row 0 is the oldest line, column 0 the oldest pixel.
	typedef logic [8:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic             emit;
		logic             lastcol;
		logic             lastrow;
		logic             top;
		logic             left;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] orow;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] col_prev;
	} item_ctl_t;

	function automatic logic [PIX_W-1:0] win_px(input win_t w, input logic [1:0] rw,
		input logic [1:0] k);
		logic [3:0] idx;
		idx = ({2'b00, rw} << 1) + {2'b00, rw} + {2'b00, k};
		return w[idx];
	endfunction

	// Weighted sum of the window; rows t, m, b and columns l, c, r are the taps, with edge
	// replication expressed by repeated indexes. A corner uses the 4 2 2 1 form.
	function automatic logic [11:0] blur_sum(input win_t w,
		input logic [1:0] t, input logic [1:0] m, input logic [1:0] b,
		input logic [1:0] l, input logic [1:0] c, input logic [1:0] r,
		input logic corner);
		logic [1:0]  v;
		logic [1:0]  h;
		logic [11:0] s;
		v = (t != m) ? t : b;
		h = (l != c) ? l : r;
		if (corner) begin
			s = {2'b00, win_px(w, m, c), 2'b00} + {3'b000, win_px(w, m, h), 1'b0}
				+ {3'b000, win_px(w, v, c), 1'b0} + {4'b0000, win_px(w, v, h)};
		end else begin
			s = {4'b0000, win_px(w, t, l)} + {3'b000, win_px(w, t, c), 1'b0}
				+ {4'b0000, win_px(w, t, r)}
				+ {3'b000, win_px(w, m, l), 1'b0} + {2'b00, win_px(w, m, c), 2'b00}
				+ {3'b000, win_px(w, m, r), 1'b0}
				+ {4'b0000, win_px(w, b, l)} + {3'b000, win_px(w, b, c), 1'b0}
				+ {4'b0000, win_px(w, b, r)};
		end
		return s;
	endfunction

endpackage

>>> hdl/gbs_line_store.sv
// Line store: one synchronous memory holding the two previous image rows per column.
// Bits 15:8 hold the row two above, bits 7:0 the row above. Uses no package items.
`timescale 1ns / 1ps

module gbs_line_store #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [15:0]              rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [15:0]              wr_data
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/gbs_window.sv
// Window stage: takes the line store read data, writes the shifted column back and
// keeps the 3x3 pixel window. Depends on gbs_pkg.
`timescale 1ns / 1ps

module gbs_window #(
	parameter int unsigned MAX_WIDTH = gbs_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [gbs_pkg::PIX_W-1:0]    in_pix,
	input  gbs_pkg::item_ctl_t           in_ctl,
	input  logic [$clog2(MAX_WIDTH)-1:0] in_addr,
	input  logic [15:0]                  lines_rd,
	output logic                         wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	output logic [15:0]                  wr_data,
	output logic                         job_valid,
	input  logic                         job_ready,
	output gbs_pkg::win_t                job_win,
	output gbs_pkg::item_ctl_t           job_ctl
);
	import gbs_pkg::*;

	localparam int unsigned AW = $clog2(MAX_WIDTH);

	logic             v_s1;
	logic [PIX_W-1:0] pix_s1;
	item_ctl_t        ctl_s1;
	logic [AW-1:0]    addr_s1;
	win_t             win_q;
	win_t             win_next;
	logic             s1_go;

	// An item without a result only shifts the window, so it never waits on the emitter.
	assign s1_go    = v_s1 && (!ctl_s1.emit || job_ready);
	assign in_ready = !v_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pix_s1  <= in_pix;
			ctl_s1  <= in_ctl;
			addr_s1 <= in_addr;
		end
	end

	always_comb begin
		win_next    = win_q;
		win_next[0] = win_q[1];
		win_next[1] = win_q[2];
		win_next[3] = win_q[4];
		win_next[4] = win_q[5];
		win_next[6] = win_q[7];
		win_next[7] = win_q[8];
		win_next[2] = lines_rd[15:8];
		win_next[5] = lines_rd[7:0];
		win_next[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_go) begin
			win_q <= win_next;
		end
	end

	// The row above moves down to the older half; the new pixel becomes the row above.
	assign wr_en   = s1_go;
	assign wr_addr = addr_s1;
	assign wr_data = {lines_rd[7:0], pix_s1};

	assign job_valid = v_s1 && ctl_s1.emit;
	assign job_win   = win_next;
	assign job_ctl   = ctl_s1;

`ifndef SYNTH
	// A column is written back before it can be read again.
	a_no_same_column: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && wr_en |-> in_addr != wr_addr)
		else $error("line store read and write hit the same column");
`endif

endmodule

>>> hdl/gbs_emitter.sv
// Emitter: holds one window snapshot, sends its one to four filtered pixels through a
// sum stage and a divide stage into the output register. Depends on gbs_pkg.
`timescale 1ns / 1ps

module gbs_emitter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	output logic                            job_ready,
	input  gbs_pkg::win_t                   job_win,
	input  gbs_pkg::item_ctl_t              job_ctl,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gbs_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast,
	output logic                            m_tuser
);
	import gbs_pkg::*;

	logic             v_s2;
	win_t             win_s2;
	item_ctl_t        ctl_s2;
	logic [3:0]       mask_s2;

	logic             v_s3;
	logic [11:0]      sum_s3;
	logic             corner_s3;
	logic [ROW_W-1:0] row_s3;
	logic [COL_W-1:0] col_s3;
	logic             last_s3;
	logic             eof_s3;

	logic [3:0]       sel;
	logic [3:0]       rest;
	logic             out_ready;
	logic             s3_ready;
	logic             fire;
	logic             cur_row;
	logic             cur_col;
	logic [1:0]       tap_t;
	logic [1:0]       tap_m;
	logic [1:0]       tap_l;
	logic [1:0]       tap_c;
	logic             corner;
	logic [11:0]      sum;
	logic [24:0]      prod;
	logic [PIX_W-1:0] pix;

	// Pending results, in emission order: diagonal neighbour, same column on the last row,
	// last column, bottom right corner.
	assign sel  = mask_s2 & (~mask_s2 + 4'd1);
	assign rest = mask_s2 & ~sel;

	assign out_ready = !m_tvalid || m_tready;
	assign s3_ready  = !v_s3 || out_ready;
	assign fire      = v_s2 && s3_ready;
	assign job_ready = !v_s2 || (fire && rest == 4'd0);

	assign cur_row = sel[1] | sel[3];
	assign cur_col = sel[2] | sel[3];
	assign tap_t   = (cur_row || ctl_s2.top) ? 2'd1 : 2'd0;
	assign tap_m   = cur_row ? 2'd2 : 2'd1;
	assign tap_l   = (cur_col || ctl_s2.left) ? 2'd1 : 2'd0;
	assign tap_c   = cur_col ? 2'd2 : 2'd1;
	assign corner  = (cur_row | ctl_s2.top) & (cur_col | ctl_s2.left);
	assign sum     = blur_sum(win_s2, tap_t, tap_m, 2'd2, tap_l, tap_c, 2'd2, corner);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			mask_s2 <= 4'd0;
		end else begin
			if (job_ready) begin
				v_s2 <= job_valid;
			end
			if (job_valid && job_ready) begin
				mask_s2 <= {job_ctl.lastcol & job_ctl.lastrow, job_ctl.lastcol,
					job_ctl.lastrow, 1'b1};
			end else if (fire) begin
				mask_s2 <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			win_s2 <= job_win;
			ctl_s2 <= job_ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_ready) begin
			v_s3 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sum_s3    <= sum;
			corner_s3 <= corner;
			row_s3    <= cur_row ? ctl_s2.row : ctl_s2.orow;
			col_s3    <= cur_col ? ctl_s2.col : ctl_s2.col_prev;
			last_s3   <= (rest == 4'd0);
			eof_s3    <= sel[3];
		end
	end

	// Corners divide by nine through the reciprocal; the rest divide by sixteen.
	assign prod = 25'(sum_s3) * 25'(RECIP9);
	assign pix  = corner_s3 ? prod[23:16] : sum_s3[11:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_ready) begin
			m_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && v_s3) begin
			m_tdata <= {4'b0000, pix, col_s3, row_s3};
			m_tlast <= last_s3;
			m_tuser <= eof_s3;
		end
	end

`ifndef SYNTH
	a_job_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> mask_s2 != 4'd0)
		else $error("held window has no pending result");
	a_eof_is_last_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && eof_s3 |-> last_s3)
		else $error("frame end result is not the last of its item");
	a_eof_is_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end item sent without tlast");
`endif

endmodule

>>> hdl/gaussian_blur_3x3_stream_unit.sv
// Top level of the streaming 3x3 Gaussian blur: configuration registers, pixel counters
// and the line store, window and emitter stages. Depends on gbs_pkg and all gbs_ modules.
`timescale 1ns / 1ps

// Usage
// Source pixels (8-bit grayscale, raster order) enter on the s_ channel, one item per
// pixel in s_tdata[7:0]. Filtered pixels leave on the m_ channel with their row and
// column; m_tlast marks the final item caused by one source pixel and m_tuser marks the
// bottom right pixel of the frame. The user sets image width and height through the APB
// port (width at address 0, height at address 4) only while idle; the block won't check.
// A pixel in row r, column c (both at least one) releases the result for (r-1, c-1);
// on the last row and last column it also releases the neighbouring edge results, up to
// four in all. Row 0 and column 0 pixels release nothing.
// A result is registered in turn by the line store read and window stage, the held window,
// the sum stage and the divide into the output register. Throughput is one pixel per cycle
// while the emitter keeps up, set by the single read and single write of the line store
// per pixel; a pixel that releases more than one result holds the emitter until all have
// left, so the last column and the last row can stall the source.
// When the receiver stalls, the output register, the sum stage and the held window fill
// and s_tready falls; nothing is dropped. Reset clears the counters, the window and all
// valid flags and loads 4096 into both size registers; the line store needs no clearing,
// as rows 0 and 1 overwrite every column before it is read into a result.

module gaussian_blur_3x3_stream_unit #(
	parameter int unsigned MAX_WIDTH = gbs_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Source pixels.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [gbs_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel_in
	// Filtered pixels.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gbs_pkg::OUT_TDATA_W-1:0] m_tdata,   // [15:0] out_row, [27:16] out_col,
	                                                   // [35:28] out_pixel, [39:36] zero
	output logic                            m_tlast,   // last_in_run
	output logic                            m_tuser,   // [0] end_of_frame
	// Configuration.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import gbs_pkg::*;

	localparam int unsigned CW  = $clog2(MAX_WIDTH);
	localparam int unsigned WW  = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
	localparam int unsigned CXW = (CW > COL_W) ? CW : COL_W;

	logic [IMG_W_W-1:0] img_width_q;
	logic [ROW_W-1:0]   img_height_q;
	logic [CW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;

	logic               cfg_wr;
	logic               accept;
	logic [WW-1:0]      width_ext;
	logic [WW-1:0]      weff;
	logic [ROW_W-1:0]   heff;
	logic               lastcol;
	logic               lastrow;
	logic [CXW-1:0]     col_ext;
	logic [CXW-1:0]     colm1_ext;
	item_ctl_t          ctl;

	logic [15:0]        lines_rd;
	logic               wr_en;
	logic [CW-1:0]      wr_addr;
	logic [15:0]        wr_data;
	logic               job_valid;
	logic               job_ready;
	win_t               job_win;
	item_ctl_t          job_ctl;

	// Configuration port: writes complete in the access cycle, reads return the register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= WIDTH_RESET;
			img_height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_IMAGE_WIDTH:  img_width_q  <= pwdata[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT: img_height_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = {19'd0, img_width_q};
			REG_IMAGE_HEIGHT: prdata = {16'd0, img_height_q};
			default:          prdata = 32'd0;
		endcase
	end

	// Effective size: width clamped to the line store depth, both at least two.
	always_comb begin
		width_ext = WW'(img_width_q);
		if (width_ext < WW'(2)) begin
			weff = WW'(2);
		end else if (width_ext > WW'(MAX_WIDTH)) begin
			weff = WW'(MAX_WIDTH);
		end else begin
			weff = width_ext;
		end
		heff = (img_height_q < 16'd2) ? 16'd2 : img_height_q;
	end

	// A counter at or past the edge counts as the edge, so a shrunken size ends the row.
	assign lastcol = (WW'(col_q) + WW'(1)) >= weff;
	assign lastrow = ({1'b0, row_q} + 17'd1) >= {1'b0, heff};

	assign col_ext   = CXW'(col_q);
	assign colm1_ext = CXW'(col_q - CW'(1));

	always_comb begin
		ctl.emit     = (row_q != 16'd0) && (col_q != CW'(0));
		ctl.lastcol  = lastcol;
		ctl.lastrow  = lastrow;
		ctl.top      = (row_q == 16'd1);
		ctl.left     = (col_q == CW'(1));
		ctl.row      = row_q;
		ctl.orow     = row_q - 16'd1;
		ctl.col      = col_ext[COL_W-1:0];
		ctl.col_prev = colm1_ext[COL_W-1:0];
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (lastcol) begin
				col_q <= '0;
				row_q <= lastrow ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// The line store is read as a pixel is accepted and written when it leaves the window
	// stage; consecutive pixels never share a column, so no forwarding is needed.
	gbs_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (lines_rd),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	gbs_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_ready  (s_tready),
		.in_pix    (s_tdata),
		.in_ctl    (ctl),
		.in_addr   (col_q),
		.lines_rd  (lines_rd),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_win   (job_win),
		.job_ctl   (job_ctl)
	);

	gbs_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_win   (job_win),
		.job_ctl   (job_ctl),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
